FILE: rtl/core/keypad_preset_event_counter_assert.svh
// Assertion macros shared by the keypad preset event counter.
`ifndef KEYPAD_PRESET_EVENT_COUNTER_ASSERT_SVH
`define KEYPAD_PRESET_EVENT_COUNTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define KPEC_ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("kpec assertion failed");

// Next-cycle implication, checked outside reset.
`define KPEC_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("kpec assertion failed");

`endif

FILE: rtl/core/kpec_pkg.sv
`timescale 1ns / 1ps

package kpec_pkg;

    localparam int MAX_DIGITS  = 5;
    localparam int DIGIT_CAP   = 7;
    localparam int DIGIT_LIMIT = (MAX_DIGITS > DIGIT_CAP) ? DIGIT_CAP : MAX_DIGITS;

    localparam int CNT_W   = 3;
    localparam int DIGIT_W = 4;
    localparam int VAL_W   = 17;
    localparam int CODE_W  = 8;
    localparam int PROD_W  = VAL_W + 4;

    localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

    localparam logic OP_KEY   = 1'b0;
    localparam logic OP_PULSE = 1'b1;

    // Active-low row/column codes
    localparam logic [CODE_W-1:0] KEY_B  = 8'hD7;
    localparam logic [CODE_W-1:0] KEY_D0 = 8'h7D;
    localparam logic [CODE_W-1:0] KEY_D1 = 8'hEE;
    localparam logic [CODE_W-1:0] KEY_D2 = 8'hED;
    localparam logic [CODE_W-1:0] KEY_D3 = 8'hEB;
    localparam logic [CODE_W-1:0] KEY_D4 = 8'hDE;
    localparam logic [CODE_W-1:0] KEY_D5 = 8'hDD;
    localparam logic [CODE_W-1:0] KEY_D6 = 8'hDB;
    localparam logic [CODE_W-1:0] KEY_D7 = 8'hBE;
    localparam logic [CODE_W-1:0] KEY_D8 = 8'hBD;
    localparam logic [CODE_W-1:0] KEY_D9 = 8'hBB;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_ENTRY = 2'd1,
        MODE_COUNT = 2'd2
    } kpec_mode_t;

    typedef struct packed {
        logic              opcode;
        logic [CODE_W-1:0] key_code;
    } kpec_event_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic [CNT_W-1:0]   digit_count;
        logic               digit_accepted;
        logic [DIGIT_W-1:0] key_digit;
        logic [VAL_W-1:0]   target_value;
        logic [VAL_W-1:0]   counted_so_far;
        logic               alarm;
    } kpec_result_t;

    typedef struct packed {
        logic               is_b;
        logic               is_digit;
        logic [DIGIT_W-1:0] digit;
    } kpec_key_t;

endpackage

FILE: rtl/core/keypad_preset_event_counter.sv
`timescale 1ns / 1ps

// Keypad preset event counter. Each event (keypad press or sensor pulse) is
// registered on entry, the mode, digit count, target and remaining count are
// updated in one combinational pass, and the result is registered on exit:
// one event per clock cycle sustained while res_stall is low, and the result
// is presented after the transaction passes the input register and then the
// result register. Key B in idle starts entry, digits build the target (up to
// five), B again loads the down counter, and pulses count it down to an alarm
// that returns the block to idle.

`include "keypad_preset_event_counter_assert.svh"

module keypad_preset_event_counter
    import kpec_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         evt_valid,
    output logic         evt_stall,
    input  kpec_event_t  evt,
    output logic         res_valid,
    input  logic         res_stall,
    output kpec_result_t res
);

    logic         in_full_reg, in_full_next;
    kpec_event_t  in_data_reg;
    logic         out_valid_reg, out_valid_next;
    kpec_result_t out_data_reg, out_data_next;

    kpec_mode_t       mode_reg, mode_next;
    logic [CNT_W-1:0] digits_reg, digits_next;
    logic [VAL_W-1:0] target_reg, target_next;
    logic [VAL_W-1:0] remaining_reg, remaining_next;

    logic             advance;
    logic             take;
    logic             fire;
    kpec_key_t        key;
    logic [PROD_W-1:0] product;
    logic [VAL_W-1:0] rem_dec;

    kpec_key_decode u_key_decode (
        .key_code (in_data_reg.key_code),
        .key      (key)
    );

    assign advance   = !out_valid_reg || !res_stall;
    assign evt_stall = in_full_reg && !advance;
    assign take      = evt_valid && !evt_stall;
    assign fire      = in_full_reg && advance;

    assign in_full_next   = take || (in_full_reg && !advance);
    assign out_valid_next = fire || (out_valid_reg && res_stall);

    // target * 10 + digit
    assign product = ({4'd0, target_reg} << 3) + ({4'd0, target_reg} << 1)
                   + PROD_W'(key.digit);
    assign rem_dec = remaining_reg - VAL_W'(remaining_reg != '0);

    always_comb
    begin
        mode_next      = mode_reg;
        digits_next    = digits_reg;
        target_next    = target_reg;
        remaining_next = remaining_reg;
        out_data_next  = '0;

        if (in_data_reg.opcode == OP_KEY)
        begin
            unique case (mode_reg)
                MODE_IDLE:
                begin
                    if (key.is_b)
                    begin
                        mode_next   = MODE_ENTRY;
                        digits_next = '0;
                        target_next = '0;
                    end
                end
                MODE_ENTRY:
                begin
                    priority if (key.is_b)
                    begin
                        remaining_next = target_reg;
                        if (target_reg == '0)
                        begin
                            out_data_next.alarm = 1'b1;
                            mode_next           = MODE_IDLE;
                            digits_next         = '0;
                        end
                        else
                        begin
                            mode_next = MODE_COUNT;
                        end
                    end
                    else if (key.is_digit && (digits_reg < CNT_W'(DIGIT_LIMIT)))
                    begin
                        target_next = (product > PROD_W'(VAL_MAX)) ? VAL_MAX
                                                                   : product[VAL_W-1:0];
                        digits_next                  = digits_reg + CNT_W'(1);
                        out_data_next.digit_accepted = 1'b1;
                        out_data_next.key_digit      = key.digit;
                    end
                    else
                    begin
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (mode_reg == MODE_COUNT)
        begin
            remaining_next = rem_dec;
            if (rem_dec == '0)
            begin
                out_data_next.alarm          = 1'b1;
                out_data_next.counted_so_far = target_reg;
                mode_next                    = MODE_IDLE;
                digits_next                  = '0;
            end
        end

        if (mode_next == MODE_COUNT)
        begin
            out_data_next.counted_so_far = target_next - remaining_next;
        end
        out_data_next.mode         = mode_next;
        out_data_next.digit_count  = digits_next;
        out_data_next.target_value = target_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_IDLE;
            digits_reg    <= '0;
            target_reg    <= '0;
            remaining_reg <= '0;
        end
        else
        begin
            in_full_reg   <= in_full_next;
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                mode_reg      <= mode_next;
                digits_reg    <= digits_next;
                target_reg    <= target_next;
                remaining_reg <= remaining_next;
            end
        end
    end

    // Payload registers: hold unless a transaction moves through
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_data_reg <= evt;
        end
        if (fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_data_reg;

    `KPEC_ASSERT_IMPLIES(a_alarm_idle, clk, rst_n, res_valid && res.alarm, res.mode == MODE_IDLE)
    `KPEC_ASSERT_IMPLIES(a_digit_in_entry, clk, rst_n, res_valid && res.digit_accepted, (res.mode == MODE_ENTRY) && (res.digit_count != '0))
    `KPEC_ASSERT_IMPLIES(a_count_nonzero, clk, rst_n, mode_reg == MODE_COUNT, remaining_reg != '0)
    `KPEC_ASSERT_NEXT(a_digits_bounded, clk, rst_n, 1'b1, digits_reg <= CNT_W'(DIGIT_LIMIT))

endmodule

FILE: rtl/core/kpec_key_decode.sv
`timescale 1ns / 1ps

module kpec_key_decode
    import kpec_pkg::*;
(
    input  logic [CODE_W-1:0] key_code,
    output kpec_key_t         key
);

    always_comb
    begin
        key.is_b     = (key_code == KEY_B);
        key.is_digit = 1'b1;
        unique case (key_code)
            KEY_D0:  key.digit = 4'd0;
            KEY_D1:  key.digit = 4'd1;
            KEY_D2:  key.digit = 4'd2;
            KEY_D3:  key.digit = 4'd3;
            KEY_D4:  key.digit = 4'd4;
            KEY_D5:  key.digit = 4'd5;
            KEY_D6:  key.digit = 4'd6;
            KEY_D7:  key.digit = 4'd7;
            KEY_D8:  key.digit = 4'd8;
            KEY_D9:  key.digit = 4'd9;
            default:
            begin
                key.digit    = '0;
                key.is_digit = 1'b0;
            end
        endcase
    end

endmodule
